FILE: design/bodo_pkg.sv
// shared types and constants for the bitmap or-downscale core
package bodo_pkg;

   // configuration register indexes
   localparam logic [0:0] REG_HIGH_WIDTH  = 1'b0;
   localparam logic [0:0] REG_HIGH_HEIGHT = 1'b1;

   // register and field widths
   localparam int CSR_W   = 12;
   localparam int LOW_X_W = 10;
   localparam int LOW_Y_W = 10;

   // dimension limits and reset value
   localparam int                 DIM_MIN   = 2;
   localparam logic [CSR_W-1:0]   DIM_RESET = 12'd2048;

   // per-pixel status from the scan counters to the row buffer
   typedef struct packed {
      logic seg_close;   // last pixel of a block column in this row
      logic emit;        // bottom-right pixel of a block
      logic frame_end;   // last pixel of the frame
      logic row_fresh;   // first row of a block row, buffer entry is stale
   } seg_flags_type;

endpackage

FILE: design/bodo_scan.sv
// raster position counters, block offsets and horizontal or of the current block column
module bodo_scan #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   localparam int CW  = $clog2(MAX_WIDTH),
   localparam int RW  = $clog2(MAX_HEIGHT),
   localparam int AW  = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
   localparam int YW  = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          restart,
   input  logic [bodo_pkg::CSR_W-1:0]    high_width,
   input  logic [bodo_pkg::CSR_W-1:0]    high_height,
   input  logic                          pix_accept,
   input  logic                          pix_bit,
   output bodo_pkg::seg_flags_type       seg_flags,
   output logic                          seg_bit,
   output logic [AW-1:0]                 seg_lx,
   output logic [YW-1:0]                 seg_ly
);

   logic [CW-1:0] col_pos_ff, col_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;
   logic [1:0]    cib_ff, cib_in;
   logic [1:0]    rib_ff, rib_in;
   logic          hacc_ff;

   int            w_eff, h_eff;
   logic [CW-1:0] last_col, last_lxw, lxw;
   logic [RW-1:0] last_row, last_lyw, lyw;
   logic          col_end, row_end, col_close, row_close;

   // clamp the programmed dimensions to the supported range
   always_comb begin
      if (int'(high_width) < bodo_pkg::DIM_MIN) begin
         w_eff = bodo_pkg::DIM_MIN;
      end else if (int'(high_width) > MAX_WIDTH) begin
         w_eff = MAX_WIDTH;
      end else begin
         w_eff = int'(high_width);
      end
      if (int'(high_height) < bodo_pkg::DIM_MIN) begin
         h_eff = bodo_pkg::DIM_MIN;
      end else if (int'(high_height) > MAX_HEIGHT) begin
         h_eff = MAX_HEIGHT;
      end else begin
         h_eff = int'(high_height);
      end
   end

   assign last_col = CW'(w_eff - 1);
   assign last_row = RW'(h_eff - 1);
   assign last_lxw = CW'((w_eff >> 1) - 1);
   assign last_lyw = RW'((h_eff >> 1) - 1);

   // block coordinates, odd edge folded into the last block
   assign lxw = ((col_pos_ff >> 1) > last_lxw) ? last_lxw : (col_pos_ff >> 1);
   assign lyw = ((row_pos_ff >> 1) > last_lyw) ? last_lyw : (row_pos_ff >> 1);

   assign col_end   = (col_pos_ff == last_col);
   assign row_end   = (row_pos_ff == last_row);
   assign col_close = col_end || ((cib_ff == 2'd1) && (lxw < last_lxw));
   assign row_close = row_end || ((rib_ff == 2'd1) && (lyw < last_lyw));

   assign seg_flags.seg_close = col_close;
   assign seg_flags.emit      = col_close && row_close;
   assign seg_flags.frame_end = col_end && row_end;
   assign seg_flags.row_fresh = (rib_ff == 2'd0);

   assign seg_bit = pix_bit | ((cib_ff == 2'd0) ? 1'b0 : hacc_ff);
   assign seg_lx  = AW'(lxw);
   assign seg_ly  = YW'(lyw);

   always_comb begin
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      cib_in     = cib_ff;
      rib_in     = rib_ff;
      if (restart) begin
         col_pos_in = '0;
         row_pos_in = '0;
         cib_in     = '0;
         rib_in     = '0;
      end else if (pix_accept) begin
         if (col_close) begin
            cib_in = '0;
         end else if (cib_ff < 2'd3) begin
            cib_in = cib_ff + 2'd1;
         end
         if (col_end) begin
            col_pos_in = '0;
            cib_in     = '0;
            if (row_close) begin
               rib_in = '0;
            end else if (rib_ff < 2'd3) begin
               rib_in = rib_ff + 2'd1;
            end
            if (row_end) begin
               row_pos_in = '0;
               rib_in     = '0;
            end else begin
               row_pos_in = row_pos_ff + RW'(1);
            end
         end else begin
            col_pos_in = col_pos_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         cib_ff     <= '0;
         rib_ff     <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         cib_ff     <= cib_in;
         rib_ff     <= rib_in;
      end
   end

   // running or of the block column within the current row
   always_ff @(posedge clock) begin
      if (pix_accept) begin
         hacc_ff <= seg_bit;
      end
   end

endmodule

FILE: design/bodo_rowbuf.sv
// per-column or row buffer with read-modify-write stage and result register
module bodo_rowbuf #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048,
   localparam int DEPTH = MAX_WIDTH / 2,
   localparam int AW    = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1,
   localparam int YW    = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            seg_valid,
   input  bodo_pkg::seg_flags_type         seg_flags,
   input  logic                            seg_bit,
   input  logic [AW-1:0]                   seg_lx,
   input  logic [YW-1:0]                   seg_ly,
   output logic                            seg_ready,
   output logic                            out_valid,
   input  logic                            out_ready,
   output logic [bodo_pkg::LOW_X_W-1:0]    out_x,
   output logic [bodo_pkg::LOW_Y_W-1:0]    out_y,
   output logic                            out_bit,
   output logic                            out_last
);

   logic          buf_mem_ff [DEPTH];
   logic          rd_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_emit_ff, s1_last_ff, s1_fresh_ff, s1_bit_ff;
   logic [AW-1:0] s1_lx_ff;
   logic [YW-1:0] s1_ly_ff;
   logic          out_valid_ff, out_valid_in;
   logic          merged, wr_en, out_load, take;

   // stale entries from an earlier block row read as zero
   assign merged   = s1_bit_ff | (s1_fresh_ff ? 1'b0 : rd_ff);
   assign wr_en    = s1_valid_ff && !s1_emit_ff;
   assign out_load = s1_valid_ff && s1_emit_ff && (!out_valid_ff || out_ready);
   assign seg_ready = !s1_valid_ff || !s1_emit_ff || !out_valid_ff || out_ready;
   assign take     = seg_valid && seg_ready;

   assign s1_valid_in  = seg_ready ? seg_valid : s1_valid_ff;
   assign out_valid_in = out_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         buf_mem_ff[s1_lx_ff] <= merged;
      end
      // forward a write to the same entry on this edge
      if (take) begin
         if (wr_en && (s1_lx_ff == seg_lx)) begin
            rd_ff <= merged;
         end else begin
            rd_ff <= buf_mem_ff[seg_lx];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_emit_ff  <= seg_flags.emit;
         s1_last_ff  <= seg_flags.frame_end;
         s1_fresh_ff <= seg_flags.row_fresh;
         s1_bit_ff   <= seg_bit;
         s1_lx_ff    <= seg_lx;
         s1_ly_ff    <= seg_ly;
      end
      if (out_load) begin
         out_x    <= bodo_pkg::LOW_X_W'(s1_lx_ff);
         out_y    <= bodo_pkg::LOW_Y_W'(s1_ly_ff);
         out_bit  <= merged;
         out_last <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign out_valid = out_valid_ff;

endmodule

FILE: design/bitmap_or_downscale_odd_edge_core.sv
// top level of the binary bitmap 2x2 or-downscaler with odd-edge merging
//
//  channel   dir   transfer when          carries
//  req_      in    tvalid & tready        one pixel bit per transfer, raster order
//  rsp_      out   tvalid & tready        one reduced block bit with its coordinates
//  csr_      in    csr_we high            width / height writes, restart the frame
//
//  one pixel per cycle while req_tready is high; the block-column or is kept in a
//  flop and the row buffer is touched once per block column per row, read at
//  acceptance and written back in the next cycle unless it completes a block
//  reset needs no clearing pass: the first row of each block row overwrites the
//  buffer entry instead of or-ing into it, so stale contents are never seen
//  req_tready drops only while a finished result waits in the read-modify-write
//  stage and the result register is still held by rsp_tready
module bitmap_or_downscale_odd_edge_core #(
   parameter int MAX_WIDTH  = 2048,
   parameter int MAX_HEIGHT = 2048
) (
   input  logic                          clock,
   input  logic                          reset,
   // pixel input
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,   // [0] high_bit, [7:1] zero
   // reduced bitmap output
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [23:0]                   rsp_tdata,   // [9:0] low_x, [19:10] low_y,
                                                      // [20] low_bit, [23:21] zero
   output logic                          rsp_tlast,   // frame_last
   // configuration writes
   input  logic                          csr_we,
   input  logic [0:0]                    csr_index,
   input  logic [bodo_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int AW = (MAX_WIDTH / 2 > 1) ? $clog2(MAX_WIDTH / 2) : 1;
   localparam int YW = (MAX_HEIGHT / 2 > 1) ? $clog2(MAX_HEIGHT / 2) : 1;

   logic [bodo_pkg::CSR_W-1:0] high_width_ff, high_width_in;
   logic [bodo_pkg::CSR_W-1:0] high_height_ff, high_height_in;

   bodo_pkg::seg_flags_type    seg_flags;
   logic                       seg_bit, seg_ready, pix_accept;
   logic [AW-1:0]              seg_lx;
   logic [YW-1:0]              seg_ly;
   logic [bodo_pkg::LOW_X_W-1:0] low_x;
   logic [bodo_pkg::LOW_Y_W-1:0] low_y;
   logic                       low_bit;

   // register writes, any write restarts the frame
   always_comb begin
      high_width_in  = high_width_ff;
      high_height_in = high_height_ff;
      if (csr_we) begin
         unique case (csr_index)
            bodo_pkg::REG_HIGH_WIDTH:  high_width_in  = csr_wdata;
            bodo_pkg::REG_HIGH_HEIGHT: high_height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_width_ff  <= bodo_pkg::DIM_RESET;
         high_height_ff <= bodo_pkg::DIM_RESET;
      end else begin
         high_width_ff  <= high_width_in;
         high_height_ff <= high_height_in;
      end
   end

   assign req_tready = seg_ready;
   assign pix_accept = req_tvalid && seg_ready;

   // position tracking and horizontal or
   bodo_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .restart     (csr_we),
      .high_width  (high_width_ff),
      .high_height (high_height_ff),
      .pix_accept  (pix_accept),
      .pix_bit     (req_tdata[0]),
      .seg_flags   (seg_flags),
      .seg_bit     (seg_bit),
      .seg_lx      (seg_lx),
      .seg_ly      (seg_ly)
   );

   // vertical or through the row buffer, one access per closed block column
   bodo_rowbuf #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_rowbuf (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (pix_accept && seg_flags.seg_close),
      .seg_flags (seg_flags),
      .seg_bit   (seg_bit),
      .seg_lx    (seg_lx),
      .seg_ly    (seg_ly),
      .seg_ready (seg_ready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_x     (low_x),
      .out_y     (low_y),
      .out_bit   (low_bit),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, low_bit, low_y, low_x};

endmodule
